// ===== rtl/xmoe_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xmoe_pkg
// Shared types and encoding constants of the x86-64 memory operand encoder.
// ----------------------------------------------------------------------------
package xmoe_pkg;

    // longest instruction: prefix, rex, two opcodes, modrm, sib, disp32
    localparam int MAX_BYTES = 10;
    localparam int IDX_W     = 4;

    // modrm mod field codes
    localparam logic [1:0] MOD_INDIRECT = 2'b00;
    localparam logic [1:0] MOD_DISP8    = 2'b01;
    localparam logic [1:0] MOD_DISP32   = 2'b10;

    // modrm r/m and sib special codes
    localparam logic [2:0] RM_SIB       = 3'b100;
    localparam logic [2:0] BASE_NO_DISP = 3'b101;
    localparam logic [2:0] SIB_NO_INDEX = 3'b100;

    // rex prefix high nibble
    localparam logic [7:0] REX_BASE = 8'h40;

    // one classified instruction: packed bytes and index of the final byte
    typedef struct packed {
        logic [IDX_W-1:0]                last_idx;
        logic [MAX_BYTES-1:0][7:0]       bytes;
    } t_insn;

    // queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage
`default_nettype wire

// ===== rtl/x86_memory_operand_encoder_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// x86_memory_operand_encoder_top
// Encodes x86-64 instructions with a base/index/displacement memory operand.
// ----------------------------------------------------------------------------
// Input channel: one instruction per beat, taken at a rising edge with push
// high and full low. Output channel: one code byte per beat, o_last_byte set
// on the final byte; the byte shows while empty is low and is taken at a
// rising edge with pop high.
// The first byte of an accepted instruction passes through the queue and then
// the output register, when both are free.
// Throughput: one byte per cycle from the output register while the receiver
// pops and the queue holds bytes; an instruction has 2 to 10 bytes, and a
// new instruction may be pushed every cycle while the queue has room.
// The front classifies in the accepting cycle and writes a queue of
// QUEUE_DEPTH instructions; full rises when that queue is full.
// Reset empties the queue and clears the output valid flag; empty goes high.
// When the receiver stalls, the byte holds, the queue fills, then full rises.
// ----------------------------------------------------------------------------
module x86_memory_operand_encoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output      logic               full,
    input  wire logic [2:0]         i_reg_field,
    input  wire logic               i_reg_extend,
    input  wire logic [3:0]         i_base_reg,
    input  wire logic               i_has_index,
    input  wire logic [3:0]         i_index_reg,
    input  wire logic [1:0]         i_scale_log2,
    input  wire logic signed [31:0] i_displacement,
    input  wire logic               i_wide_operand,
    input  wire logic [7:0]         i_prefix_byte,
    input  wire logic [7:0]         i_opcode_first,
    input  wire logic [7:0]         i_opcode_second,
    output      logic               empty,
    input  wire logic               pop,
    output      logic [7:0]         o_code_byte,
    output      logic               o_last_byte
);

    xmoe_pkg::t_insn   front_insn;
    xmoe_pkg::t_insn   head_insn;
    xmoe_pkg::t_q_stat q_stat;
    logic              q_rd;

    // front: classify and pack
    xmoe_front u_front (
        .i_reg_field     (i_reg_field),
        .i_reg_extend    (i_reg_extend),
        .i_base_reg      (i_base_reg),
        .i_has_index     (i_has_index),
        .i_index_reg     (i_index_reg),
        .i_scale_log2    (i_scale_log2),
        .i_displacement  (i_displacement),
        .i_wide_operand  (i_wide_operand),
        .i_prefix_byte   (i_prefix_byte),
        .i_opcode_first  (i_opcode_first),
        .i_opcode_second (i_opcode_second),
        .o_insn          (front_insn)
    );

    // queue between front and back
    xmoe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (push),
        .i_wr_data (front_insn),
        .i_rd      (q_rd),
        .o_head    (head_insn),
        .o_stat    (q_stat)
    );

    assign full = q_stat.full;

    // back: serialize bytes
    xmoe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_insn),
        .i_stat      (q_stat),
        .o_rd        (q_rd),
        .empty       (empty),
        .pop         (pop),
        .o_code_byte (o_code_byte),
        .o_last_byte (o_last_byte)
    );

endmodule
`default_nettype wire

// ===== rtl/xmoe_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xmoe_front
// Classifies one instruction: picks mod, sib and rex, and packs its bytes.
// ----------------------------------------------------------------------------
module xmoe_front (
    input  wire logic [2:0]         i_reg_field,
    input  wire logic               i_reg_extend,
    input  wire logic [3:0]         i_base_reg,
    input  wire logic               i_has_index,
    input  wire logic [3:0]         i_index_reg,
    input  wire logic [1:0]         i_scale_log2,
    input  wire logic signed [31:0] i_displacement,
    input  wire logic               i_wide_operand,
    input  wire logic [7:0]         i_prefix_byte,
    input  wire logic [7:0]         i_opcode_first,
    input  wire logic [7:0]         i_opcode_second,
    output      xmoe_pkg::t_insn    o_insn
);

    logic [2:0]  base3;
    logic        use_sib;
    logic        disp_zero;
    logic        disp_fits8;
    logic [1:0]  mod_sel;
    logic [3:0]  rex_bits;
    logic        has_rex;
    logic        has_pre;
    logic        has_op2;
    logic [2:0]  rm3;
    logic [xmoe_pkg::IDX_W-1:0] p_rex, p_op1, p_op2, p_modrm, p_sib;
    logic [xmoe_pkg::IDX_W-1:0] p_d0, p_d1, p_d2, p_d3;

    // addressing form
    assign base3      = i_base_reg[2:0];
    assign use_sib    = i_has_index || (base3 == xmoe_pkg::RM_SIB);
    assign disp_zero  = (i_displacement == 32'sd0);
    assign disp_fits8 = (&i_displacement[31:7]) || !(|i_displacement[31:7]);
    assign rm3        = use_sib ? xmoe_pkg::RM_SIB : base3;

    always_comb begin
        if (disp_zero && (base3 != xmoe_pkg::BASE_NO_DISP)) begin
            mod_sel = xmoe_pkg::MOD_INDIRECT;
        end else if (disp_fits8) begin
            mod_sel = xmoe_pkg::MOD_DISP8;
        end else begin
            mod_sel = xmoe_pkg::MOD_DISP32;
        end
    end

    // optional bytes
    assign rex_bits = {i_wide_operand, i_reg_extend, i_has_index & i_index_reg[3],
                       i_base_reg[3]};
    assign has_rex  = |rex_bits;
    assign has_pre  = |i_prefix_byte;
    assign has_op2  = |i_opcode_second;

    // byte positions
    assign p_rex   = {3'b000, has_pre};
    assign p_op1   = p_rex + {3'b000, has_rex};
    assign p_op2   = p_op1 + 4'd1;
    assign p_modrm = p_op2 + {3'b000, has_op2};
    assign p_sib   = p_modrm + 4'd1;
    assign p_d0    = p_sib + {3'b000, use_sib};
    assign p_d1    = p_d0 + 4'd1;
    assign p_d2    = p_d0 + 4'd2;
    assign p_d3    = p_d0 + 4'd3;

    // pack bytes
    always_comb begin
        o_insn = '0;
        if (has_pre) begin
            o_insn.bytes[0] = i_prefix_byte;
        end
        if (has_rex) begin
            o_insn.bytes[p_rex] = xmoe_pkg::REX_BASE | {4'b0000, rex_bits};
        end
        o_insn.bytes[p_op1] = i_opcode_first;
        if (has_op2) begin
            o_insn.bytes[p_op2] = i_opcode_second;
        end
        o_insn.bytes[p_modrm] = {mod_sel, i_reg_field, rm3};
        if (use_sib) begin
            if (i_has_index) begin
                o_insn.bytes[p_sib] = {i_scale_log2, i_index_reg[2:0], base3};
            end else begin
                o_insn.bytes[p_sib] = {2'b00, xmoe_pkg::SIB_NO_INDEX, base3};
            end
        end
        if (mod_sel == xmoe_pkg::MOD_DISP8) begin
            o_insn.bytes[p_d0] = i_displacement[7:0];
            o_insn.last_idx    = p_d0;
        end else if (mod_sel == xmoe_pkg::MOD_DISP32) begin
            o_insn.bytes[p_d0] = i_displacement[7:0];
            o_insn.bytes[p_d1] = i_displacement[15:8];
            o_insn.bytes[p_d2] = i_displacement[23:16];
            o_insn.bytes[p_d3] = i_displacement[31:24];
            o_insn.last_idx    = p_d3;
        end else begin
            o_insn.last_idx    = p_d0 - 4'd1;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/xmoe_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xmoe_queue
// Short queue of classified instructions between the front and the back.
// ----------------------------------------------------------------------------
module xmoe_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr,
    input  wire xmoe_pkg::t_insn i_wr_data,
    input  wire logic            i_rd,
    output      xmoe_pkg::t_insn o_head,
    output      xmoe_pkg::t_q_stat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    xmoe_pkg::t_insn    r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               do_wr;
    logic               do_rd;

    // status and head
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_wr        = i_wr && !o_stat.full;
    assign do_rd        = i_rd && !o_stat.empty;

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_wr && !do_rd) |=> (r_count == CNT_W'($past(r_count) + 1'b1)))
        else $error("queue count missed a write");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_rd && !do_wr) |=> (r_count == CNT_W'($past(r_count) - 1'b1)))
        else $error("queue count missed a read");

endmodule
`default_nettype wire

// ===== rtl/xmoe_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xmoe_back
// Walks the head instruction byte by byte into the output register.
// ----------------------------------------------------------------------------
module xmoe_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire xmoe_pkg::t_insn   i_head,
    input  wire xmoe_pkg::t_q_stat i_stat,
    output      logic              o_rd,
    output      logic              empty,
    input  wire logic              pop,
    output      logic [7:0]        o_code_byte,
    output      logic              o_last_byte
);

    logic [xmoe_pkg::IDX_W-1:0] r_idx, n_idx;
    logic                       r_out_valid, n_out_valid;
    logic [7:0]                 r_byte;
    logic                       r_last;
    logic                       load;
    logic                       at_last;

    // load a byte when the output register is free or being taken
    assign load    = !i_stat.empty && (!r_out_valid || pop);
    assign at_last = (r_idx == i_head.last_idx);
    assign o_rd    = load && at_last;

    always_comb begin
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (load) begin
            n_idx       = at_last ? '0 : r_idx + 1'b1;
            n_out_valid = 1'b1;
        end else if (pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_head.bytes[r_idx];
            r_last <= at_last;
        end
    end

    assign empty       = !r_out_valid;
    assign o_code_byte = r_byte;
    assign o_last_byte = r_last;

    // checks
    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.empty |-> (r_idx == '0))
        else $error("byte index left mid instruction with empty queue");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stat.empty |-> (r_idx <= i_head.last_idx))
        else $error("byte index past final byte");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_out_valid && (r_last == $past(at_last))))
        else $error("loaded byte not presented");

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the x86-64 memory operand encoder. It sends instructions
// through the push/full queue port and predicts the byte stream of each
// one (prefix, rex, opcodes, modrm, sib, displacement). A checker compares
// every popped code byte and its last flag with the oldest predicted beat.
// Stimulus is directed corner cases, a back-pressure phase and random
// instructions, the random ones partly under random idling on both sides.
// ----------------------------------------------------------------------------
module tb;

    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 20;
    localparam int LONG_HOLD    = 300;

    // one instruction as offered on the input ports
    typedef struct {
        logic [2:0]         reg_field;
        logic               reg_extend;
        logic [3:0]         base_reg;
        logic               has_index;
        logic [3:0]         index_reg;
        logic [1:0]         scale_log2;
        logic signed [31:0] displacement;
        logic               wide_operand;
        logic [7:0]         prefix_byte;
        logic [7:0]         opcode_first;
        logic [7:0]         opcode_second;
    } t_tb_insn;

    // one output beat: a code byte and its last flag
    typedef struct {
        logic [7:0] value;
        logic       last;
    } t_code_beat;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               push            = 1'b0;
    logic               pop             = 1'b0;
    logic [2:0]         i_reg_field     = '0;
    logic               i_reg_extend    = 1'b0;
    logic [3:0]         i_base_reg      = '0;
    logic               i_has_index     = 1'b0;
    logic [3:0]         i_index_reg     = '0;
    logic [1:0]         i_scale_log2    = '0;
    logic signed [31:0] i_displacement  = '0;
    logic               i_wide_operand  = 1'b0;
    logic [7:0]         i_prefix_byte   = '0;
    logic [7:0]         i_opcode_first  = '0;
    logic [7:0]         i_opcode_second = '0;
    logic               full;
    logic               empty;
    logic [7:0]         o_code_byte;
    logic               o_last_byte;

    t_code_beat code_bytes_due[$];
    t_code_beat due_beat;
    int         errors        = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         hold_request  = 0;
    int         hold_left     = 0;

    x86_memory_operand_encoder_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_reg_field     (i_reg_field),
        .i_reg_extend    (i_reg_extend),
        .i_base_reg      (i_base_reg),
        .i_has_index     (i_has_index),
        .i_index_reg     (i_index_reg),
        .i_scale_log2    (i_scale_log2),
        .i_displacement  (i_displacement),
        .i_wide_operand  (i_wide_operand),
        .i_prefix_byte   (i_prefix_byte),
        .i_opcode_first  (i_opcode_first),
        .i_opcode_second (i_opcode_second),
        .empty           (empty),
        .pop             (pop),
        .o_code_byte     (o_code_byte),
        .o_last_byte     (o_last_byte)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // append one predicted byte to the due queue
    function automatic void queue_beat(input logic [7:0] value);
        t_code_beat b;
        b.value = value;
        b.last  = 1'b0;
        code_bytes_due.insert(code_bytes_due.size(), b);
    endfunction

    // byte stream of one instruction, appended to the due queue
    function automatic void encode_insn(input t_tb_insn in);
        logic [1:0] mod_f;
        logic [2:0] base_lo;
        logic [3:0] rex_bits;
        logic       use_sib;
        base_lo  = in.base_reg[2:0];
        use_sib  = in.has_index || (base_lo == xmoe_pkg::RM_SIB);
        rex_bits = {in.wide_operand, in.reg_extend,
                    in.has_index & in.index_reg[3], in.base_reg[3]};
        // rbp/r13 as base cannot use mod 00, it means disp32 without base
        if (in.displacement == 0 && base_lo != xmoe_pkg::BASE_NO_DISP)
            mod_f = xmoe_pkg::MOD_INDIRECT;
        else if (in.displacement >= -128 && in.displacement <= 127)
            mod_f = xmoe_pkg::MOD_DISP8;
        else
            mod_f = xmoe_pkg::MOD_DISP32;
        if (in.prefix_byte != 8'h00)
            queue_beat(in.prefix_byte);
        if (rex_bits != 4'h0)
            queue_beat(xmoe_pkg::REX_BASE | {4'h0, rex_bits});
        queue_beat(in.opcode_first);
        if (in.opcode_second != 8'h00)
            queue_beat(in.opcode_second);
        queue_beat({mod_f, in.reg_field, use_sib ? xmoe_pkg::RM_SIB : base_lo});
        // sib: scaled index, or the no-index code when only rsp/r12 forced it
        if (use_sib) begin
            if (in.has_index)
                queue_beat({in.scale_log2, in.index_reg[2:0], base_lo});
            else
                queue_beat({2'b00, xmoe_pkg::SIB_NO_INDEX, base_lo});
        end
        // displacement, little endian
        if (mod_f == xmoe_pkg::MOD_DISP8) begin
            queue_beat(in.displacement[7:0]);
        end else if (mod_f == xmoe_pkg::MOD_DISP32) begin
            queue_beat(in.displacement[7:0]);
            queue_beat(in.displacement[15:8]);
            queue_beat(in.displacement[23:16]);
            queue_beat(in.displacement[31:24]);
        end
        code_bytes_due[code_bytes_due.size() - 1].last = 1'b1;
    endfunction

    function automatic t_tb_insn mk_insn(
        input logic [2:0]  reg_f,
        input logic        rex_r,
        input logic [3:0]  base,
        input logic        has_idx,
        input logic [3:0]  idx,
        input logic [1:0]  scale,
        input logic [31:0] disp,
        input logic        wide,
        input logic [7:0]  prefix,
        input logic [7:0]  op1,
        input logic [7:0]  op2
    );
        t_tb_insn r;
        r.reg_field     = reg_f;
        r.reg_extend    = rex_r;
        r.base_reg      = base;
        r.has_index     = has_idx;
        r.index_reg     = idx;
        r.scale_log2    = scale;
        r.displacement  = disp;
        r.wide_operand  = wide;
        r.prefix_byte   = prefix;
        r.opcode_first  = op1;
        r.opcode_second = op2;
        return r;
    endfunction

    // random instruction, biased toward the mod and sib corner cases
    function automatic t_tb_insn random_insn();
        t_tb_insn r;
        int    disp_edges[4] = '{-129, -128, 127, 128};
        logic [7:0] prefixes[3] = '{8'h66, 8'hF2, 8'hF3};
        r.reg_field  = 3'($urandom_range(7));
        r.reg_extend = 1'($urandom_range(1));
        r.base_reg   = 4'($urandom_range(15));
        if ($urandom_range(3) == 0)
            r.base_reg[2:0] = $urandom_range(1) ? xmoe_pkg::RM_SIB : xmoe_pkg::BASE_NO_DISP;
        r.has_index  = 1'($urandom_range(1));
        r.index_reg  = 4'($urandom_range(15));
        r.scale_log2 = 2'($urandom_range(3));
        case ($urandom_range(9))
            0, 1:    r.displacement = 0;
            2, 3, 4: r.displacement = int'($urandom_range(255)) - 128;
            5:       r.displacement = disp_edges[$urandom_range(3)];
            default: r.displacement = $urandom;
        endcase
        r.wide_operand = 1'($urandom_range(1));
        case ($urandom_range(3))
            0, 1:    r.prefix_byte = 8'h00;
            2:       r.prefix_byte = prefixes[$urandom_range(2)];
            default: r.prefix_byte = 8'($urandom_range(255));
        endcase
        r.opcode_first  = 8'($urandom_range(255));
        r.opcode_second = $urandom_range(1) ? 8'h00 : 8'($urandom_range(255));
        return r;
    endfunction

    // offer one instruction, hold it until the queue takes it
    task automatic send_insn(input t_tb_insn in);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push            <= 1'b1;
        i_reg_field     <= in.reg_field;
        i_reg_extend    <= in.reg_extend;
        i_base_reg      <= in.base_reg;
        i_has_index     <= in.has_index;
        i_index_reg     <= in.index_reg;
        i_scale_log2    <= in.scale_log2;
        i_displacement  <= in.displacement;
        i_wide_operand  <= in.wide_operand;
        i_prefix_byte   <= in.prefix_byte;
        i_opcode_first  <= in.opcode_first;
        i_opcode_second <= in.opcode_second;
        do @(posedge i_clk); while (full);
        encode_insn(in);
    endtask

    // stop offering and wait until every predicted beat is out
    task automatic wait_drained();
        push <= 1'b0;
        while (code_bytes_due.size() != 0)
            @(posedge i_clk);
    endtask

    // corner cases of mod, sib, rex, prefix and opcode handling
    task automatic test_encoding_corners();
        // shortest form: one opcode and modrm
        send_insn(mk_insn(0, 0, 0, 0, 0, 0, 0, 0, 8'h00, 8'h8B, 8'h00));
        // longest form: every optional byte present, fields at their maximum
        send_insn(mk_insn(7, 1, 15, 1, 15, 3, 32'h7FFF_FFFF, 1, 8'hFF, 8'hFF, 8'hFF));
        // rbp and r13 base with zero displacement take a disp8 of zero
        send_insn(mk_insn(3, 0, 5, 0, 0, 0, 0, 0, 8'h00, 8'h89, 8'h00));
        send_insn(mk_insn(2, 1, 13, 0, 0, 0, 0, 1, 8'h00, 8'h8B, 8'h00));
        // rsp and r12 base force a sib, index fields ignored without index
        send_insn(mk_insn(1, 0, 4, 0, 0, 0, 0, 0, 8'h00, 8'h8B, 8'h00));
        send_insn(mk_insn(6, 0, 12, 0, 9, 2, 0, 0, 8'h00, 8'h8B, 8'h00));
        // disp8 and disp32 boundaries
        send_insn(mk_insn(0, 0, 0, 0, 0, 0, -128, 0, 8'h00, 8'h01, 8'h00));
        send_insn(mk_insn(0, 0, 1, 0, 0, 0, 127, 0, 8'h00, 8'h01, 8'h00));
        send_insn(mk_insn(0, 0, 2, 0, 0, 0, -129, 0, 8'h00, 8'h01, 8'h00));
        send_insn(mk_insn(0, 0, 3, 0, 0, 0, 128, 0, 8'h00, 8'h01, 8'h00));
        send_insn(mk_insn(5, 0, 6, 0, 0, 0, 32'h8000_0000, 0, 8'h00, 8'h03, 8'h00));
        send_insn(mk_insn(4, 0, 7, 0, 0, 0, 32'hFFFF_FFFF, 0, 8'h00, 8'h03, 8'h00));
        // rsp as index: encoded as given, with and without rex.x
        send_insn(mk_insn(0, 0, 0, 1, 4, 1, 0, 0, 8'h00, 8'h8D, 8'h00));
        send_insn(mk_insn(2, 0, 1, 1, 12, 3, 16, 0, 8'h00, 8'h8D, 8'h00));
        // scaled index on an rbp base still needs the disp8
        send_insn(mk_insn(3, 0, 5, 1, 3, 2, 0, 0, 8'h00, 8'h8B, 8'h00));
        // zero first opcode is emitted, zero second opcode is not
        send_insn(mk_insn(0, 0, 0, 0, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00));
        send_insn(mk_insn(1, 0, 8, 0, 0, 0, 8, 0, 8'h66, 8'h0F, 8'h38));
        send_insn(mk_insn(1, 1, 9, 1, 10, 1, 300, 1, 8'hF3, 8'h0F, 8'hB8));
        // index bit 3 without an index must not set rex.x
        send_insn(mk_insn(0, 0, 0, 0, 15, 3, 0, 0, 8'h00, 8'h8B, 8'h00));
        // each rex bit on its own
        send_insn(mk_insn(0, 1, 0, 0, 0, 0, 0, 0, 8'h00, 8'h8B, 8'h00));
        send_insn(mk_insn(0, 0, 0, 0, 0, 0, 0, 1, 8'h00, 8'h8B, 8'h00));
        send_insn(mk_insn(0, 0, 0, 1, 8, 0, 0, 0, 8'h00, 8'h8B, 8'h00));
        send_insn(mk_insn(0, 0, 8, 0, 0, 0, 0, 0, 8'h00, 8'h8B, 8'h00));
        wait_drained();
    endtask

    // receiver stalls long enough for the queue to fill and raise full
    task automatic test_queue_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait_drained();
        hold_request = LONG_HOLD;
        repeat (16)
            send_insn(random_insn());
        // sender pauses until the whole backlog is out
        wait_drained();
    endtask

    task automatic test_random_insns(input int count);
        repeat (count)
            send_insn(random_insn());
    endtask

    // result checker and receiver pacing
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (code_bytes_due.size() == 0) begin
                    $display("%0t: unexpected beat: expected none, actual byte %02h last %0b",
                             $time, o_code_byte, o_last_byte);
                    errors++;
                end else begin
                    due_beat = code_bytes_due.pop_front();
                    if (o_code_byte !== due_beat.value) begin
                        $display("%0t: code byte mismatch: expected %02h, actual %02h",
                                 $time, due_beat.value, o_code_byte);
                        errors++;
                    end
                    if (o_last_byte !== due_beat.last) begin
                        $display("%0t: last flag mismatch: expected %0b, actual %0b",
                                 $time, due_beat.last, o_last_byte);
                        errors++;
                    end
                end
            end
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog on cycles without any beat
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // test sequence
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_encoding_corners();
        test_queue_backpressure();

        send_idle_pct = 24;
        recv_idle_pct = 51;
        test_random_insns(125);
        send_idle_pct = 51;
        recv_idle_pct = 24;
        test_random_insns(125);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_insns(125);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && code_bytes_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
